// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define RDBP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also runs through reset
`define RDBP_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/rdbp_pkg.sv
// ----------------------------------------------------------------------------
// rdbp_pkg
// Types and constants of the route discovery best path block.
// ----------------------------------------------------------------------------
package rdbp_pkg;

  localparam int FUNC_W    = 3;
  localparam int ID_W      = 8;
  localparam int LEN_W     = 5;
  localparam int RESP_W    = 9;
  localparam int TIMEOUT_W = 16;
  localparam int AGE_W     = 17;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;
  localparam logic [AGE_W-1:0]     AGE_MAX       = 17'h1FFFF;

  localparam logic [FUNC_W-1:0] FUNC_DISCOVER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NACK     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROUTE    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

  typedef enum logic [1:0] {
    VERDICT_EQ,
    VERDICT_LT,
    VERDICT_GT
  } verdict_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WD_RD,
    ST_WD_CHK,
    ST_NOTE_RD,
    ST_NOTE_CHK,
    ST_HOP_RD,
    ST_HOP_CHK,
    ST_HOP_END,
    ST_TICK,
    ST_EMIT,
    ST_RD_REQ,
    ST_RD_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clr_sweep;
    logic map_rd_wd;
    logic map_rd_src;
    logic wd_update;
    logic note_update;
    logic path_rd_hop;
    logic hop_update;
    logic hop_finish;
    logic tick;
    logic path_rd_out;
    logic rd_advance;
    logic emit_status;
    logic emit_path;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hop_last;
    logic              best_empty;
    logic              rd_last;
    logic              clr_done;
    logic              out_free;
    logic              exp_flag;
  } sts_t;

endpackage

// File: rtl/rdbp_if.sv
// ----------------------------------------------------------------------------
// rdbp_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface rdbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [rdbp_pkg::FUNC_W-1:0]   func;
  logic [rdbp_pkg::ID_W-1:0]     responder_id;
  logic [rdbp_pkg::LEN_W-1:0]    path_len;
  logic [rdbp_pkg::ID_W-1:0]     hop_node;
  logic                          hop_last;

  modport source (output valid, func, responder_id, path_len, hop_node, hop_last,
                  input ready);
  modport sink (input valid, func, responder_id, path_len, hop_node, hop_last,
                output ready);
endinterface

interface rdbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [rdbp_pkg::RESP_W-1:0]   responses;
  logic                          route_found;
  logic                          expired;
  logic [rdbp_pkg::LEN_W-1:0]    best_len;
  logic [rdbp_pkg::ID_W-1:0]     out_node;
  logic                          out_last;

  modport source (output valid, responses, route_found, expired, best_len, out_node,
                  out_last, input ready);
  modport sink (input valid, responses, route_found, expired, best_len, out_node,
                out_last, output ready);
endinterface

// File: rtl/route_discovery_best_path.sv
// Steps: discover withdraws via a map read and update, then, like nack, notes
//   its responder likewise; a route hop adds a path read and compare, and the
//   last hop a best path update; tick ages; all end in the result register.
// One transaction at a time; a read gives its hops one by one, paced by the
//   registered path RAM read. Reset: synchronous; a sweep then clears the
//   responder map, also after each expiry; no input is taken during the sweep.
// ----------------------------------------------------------------------------
// route_discovery_best_path
// Route discovery record for one destination: distinct responder count,
// responder map with discover withdraw, best path selection and aging.
// ----------------------------------------------------------------------------
module route_discovery_best_path #(
  parameter int MAX_NODES = 256,
  parameter int MAX_HOPS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rdbp_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  rdbp_in_if.sink                        item,
  rdbp_out_if.source                     result
);

  rdbp_pkg::cmd_t cmd;
  rdbp_pkg::sts_t sts;

  rdbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .func     (item.func),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdbp_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_HOPS  (MAX_HOPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .func            (item.func),
    .responder_id    (item.responder_id),
    .path_len        (item.path_len),
    .hop_node        (item.hop_node),
    .hop_last        (item.hop_last),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_responses   (result.responses),
    .out_route_found (result.route_found),
    .out_expired     (result.expired),
    .out_best_len    (result.best_len),
    .out_node        (result.out_node),
    .out_last        (result.out_last)
  );

endmodule

// File: rtl/rdbp_ram.sv
// ----------------------------------------------------------------------------
// rdbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rdbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rdbp_ctrl.sv
// ----------------------------------------------------------------------------
// rdbp_ctrl
// Sequencer: steps one transaction through map lookups, path compare,
// aging, readout and the responder map clearing sweep.
// ----------------------------------------------------------------------------
module rdbp_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rdbp_pkg::FUNC_W-1:0] func,
  input  rdbp_pkg::sts_t              sts,
  output rdbp_pkg::cmd_t              cmd
);

  rdbp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdbp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      rdbp_pkg::ST_CLEAR: begin
        cmd.clr_sweep = 1'b1;
        if (sts.clr_done) begin
          state_next = rdbp_pkg::ST_IDLE;
        end
      end
      rdbp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          priority if (func == rdbp_pkg::FUNC_DISCOVER) begin
            state_next = rdbp_pkg::ST_WD_RD;
          end else if (func == rdbp_pkg::FUNC_NACK || func == rdbp_pkg::FUNC_ROUTE) begin
            state_next = rdbp_pkg::ST_NOTE_RD;
          end else if (func == rdbp_pkg::FUNC_TICK) begin
            state_next = rdbp_pkg::ST_TICK;
          end else if (func == rdbp_pkg::FUNC_READ && !sts.best_empty) begin
            state_next = rdbp_pkg::ST_RD_REQ;
          end else begin
            state_next = rdbp_pkg::ST_EMIT;
          end
        end
      end
      rdbp_pkg::ST_WD_RD: begin
        cmd.map_rd_wd = 1'b1;
        state_next    = rdbp_pkg::ST_WD_CHK;
      end
      rdbp_pkg::ST_WD_CHK: begin
        cmd.wd_update = 1'b1;
        state_next    = rdbp_pkg::ST_NOTE_RD;
      end
      rdbp_pkg::ST_NOTE_RD: begin
        cmd.map_rd_src = 1'b1;
        state_next     = rdbp_pkg::ST_NOTE_CHK;
      end
      rdbp_pkg::ST_NOTE_CHK: begin
        cmd.note_update = 1'b1;
        state_next      = (sts.func == rdbp_pkg::FUNC_ROUTE) ? rdbp_pkg::ST_HOP_RD
                                                             : rdbp_pkg::ST_EMIT;
      end
      rdbp_pkg::ST_HOP_RD: begin
        cmd.path_rd_hop = 1'b1;
        state_next      = rdbp_pkg::ST_HOP_CHK;
      end
      rdbp_pkg::ST_HOP_CHK: begin
        cmd.hop_update = 1'b1;
        state_next     = sts.hop_last ? rdbp_pkg::ST_HOP_END : rdbp_pkg::ST_EMIT;
      end
      rdbp_pkg::ST_HOP_END: begin
        cmd.hop_finish = 1'b1;
        state_next     = rdbp_pkg::ST_EMIT;
      end
      rdbp_pkg::ST_TICK: begin
        cmd.tick   = 1'b1;
        state_next = rdbp_pkg::ST_EMIT;
      end
      rdbp_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          // an expiry wipes the responder map before the next transaction
          state_next      = sts.exp_flag ? rdbp_pkg::ST_CLEAR : rdbp_pkg::ST_IDLE;
        end
      end
      rdbp_pkg::ST_RD_REQ: begin
        cmd.path_rd_out = 1'b1;
        state_next      = rdbp_pkg::ST_RD_EMIT;
      end
      rdbp_pkg::ST_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_path  = 1'b1;
          cmd.rd_advance = 1'b1;
          state_next     = sts.rd_last ? rdbp_pkg::ST_IDLE : rdbp_pkg::ST_RD_REQ;
        end
      end
      default: begin
        state_next = rdbp_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/rdbp_dp.sv
// ----------------------------------------------------------------------------
// rdbp_dp
// Datapath: responder map RAM, path RAM with two banks, record registers,
// aging counter and the result register.
// ----------------------------------------------------------------------------
module rdbp_dp #(
  parameter int MAX_NODES = 256,
  parameter int MAX_HOPS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rdbp_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  input  logic [rdbp_pkg::FUNC_W-1:0]    func,
  input  logic [rdbp_pkg::ID_W-1:0]      responder_id,
  input  logic [rdbp_pkg::LEN_W-1:0]     path_len,
  input  logic [rdbp_pkg::ID_W-1:0]      hop_node,
  input  logic                           hop_last,
  input  rdbp_pkg::cmd_t                 cmd,
  output rdbp_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rdbp_pkg::RESP_W-1:0]    out_responses,
  output logic                           out_route_found,
  output logic                           out_expired,
  output logic [rdbp_pkg::LEN_W-1:0]     out_best_len,
  output logic [rdbp_pkg::ID_W-1:0]      out_node,
  output logic                           out_last
);

  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int NCNT_W     = $clog2(MAX_NODES + 1);
  localparam int HOP_AW     = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int HCNT_W     = $clog2(MAX_HOPS + 1);
  localparam int PATH_DEPTH = 2 * (1 << HOP_AW);

  // latched transaction
  logic [rdbp_pkg::FUNC_W-1:0] cur_func;
  logic [rdbp_pkg::ID_W-1:0]   cur_src;
  logic [rdbp_pkg::LEN_W-1:0]  cur_plen;
  logic [rdbp_pkg::ID_W-1:0]   cur_node;
  logic                        cur_last;

  // record state
  logic [rdbp_pkg::TIMEOUT_W-1:0] timeout;
  logic [NCNT_W-1:0]              count;
  logic [rdbp_pkg::ID_W-1:0]      withdraw_id;
  logic                           have_route;
  logic [HCNT_W-1:0]              best_len;
  logic [HCNT_W-1:0]              hop_pos;
  rdbp_pkg::verdict_t             verdict;
  logic [rdbp_pkg::AGE_W-1:0]     age;
  logic                           best_bank;
  logic                           exp_flag;
  logic [HCNT_W-1:0]              rd_idx;
  logic [NODE_AW-1:0]             clr_addr;

  // map RAM
  logic               map_we;
  logic [NODE_AW-1:0] map_waddr;
  logic               map_re;
  logic [NODE_AW-1:0] map_raddr;
  logic               map_rdata;

  // path RAM
  logic                path_we;
  logic [HOP_AW:0]     path_waddr;
  logic                path_re;
  logic [HOP_AW:0]     path_raddr;
  logic [rdbp_pkg::ID_W-1:0] path_rdata;

  logic [31:0]              src_ext;
  logic [31:0]              wd_ext;
  logic [31:0]              count_ext;
  logic [31:0]              blen_ext;
  logic                     src_ok;
  logic                     wd_ok;
  logic [NODE_AW-1:0]       src_addr;
  logic [NODE_AW-1:0]       wd_addr;
  logic                     wd_hit;
  logic                     note_new;
  logic [rdbp_pkg::AGE_W-1:0] age_inc;
  logic                     expire_now;
  logic [HCNT_W-1:0]        lim;
  logic                     hop_in;
  logic [HCNT_W-1:0]        n_hops;
  logic                     new_wins;
  logic                     rd_last;

  assign src_ext  = 32'(cur_src);
  assign wd_ext   = 32'(withdraw_id);
  assign src_ok   = src_ext < 32'(MAX_NODES);
  assign wd_ok    = (withdraw_id != '0) && (wd_ext < 32'(MAX_NODES));
  assign src_addr = src_ext[NODE_AW-1:0];
  assign wd_addr  = wd_ext[NODE_AW-1:0];
  assign wd_hit   = wd_ok && map_rdata;
  assign note_new = src_ok && !map_rdata;

  assign age_inc    = (age < rdbp_pkg::AGE_MAX) ? age + 1'b1 : age;
  assign expire_now = age_inc > {1'b0, timeout};

  assign lim    = (32'(cur_plen) < 32'(MAX_HOPS)) ? HCNT_W'(cur_plen) : HCNT_W'(MAX_HOPS);
  assign hop_in = hop_pos < lim;
  assign n_hops = hop_in ? hop_pos : lim;
  assign new_wins = !have_route || (best_len > n_hops) ||
                    (best_len == n_hops && verdict == rdbp_pkg::VERDICT_LT);
  assign rd_last = ({1'b0, rd_idx} + 1'b1) == {1'b0, best_len};

  assign map_we    = cmd.clr_sweep || (cmd.wd_update && wd_hit) ||
                     (cmd.note_update && note_new);
  assign map_waddr = cmd.clr_sweep ? clr_addr : (cmd.wd_update ? wd_addr : src_addr);
  assign map_re    = cmd.map_rd_wd || cmd.map_rd_src;
  assign map_raddr = cmd.map_rd_wd ? wd_addr : src_addr;

  // candidate hops go to the bank that does not hold the best path
  assign path_we    = cmd.hop_update && hop_in;
  assign path_waddr = {~best_bank, hop_pos[HOP_AW-1:0]};
  assign path_re    = cmd.path_rd_hop || cmd.path_rd_out;
  assign path_raddr = cmd.path_rd_hop ? {best_bank, hop_pos[HOP_AW-1:0]}
                                      : {best_bank, rd_idx[HOP_AW-1:0]};

  rdbp_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NODES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (cmd.note_update),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  rdbp_ram #(
    .WIDTH (rdbp_pkg::ID_W),
    .DEPTH (PATH_DEPTH)
  ) u_path_ram (
    .clk   (clk),
    .we    (path_we),
    .waddr (path_waddr),
    .wdata (cur_node),
    .re    (path_re),
    .raddr (path_raddr),
    .rdata (path_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_func <= func;
      cur_src  <= responder_id;
      cur_plen <= path_len;
      cur_node <= hop_node;
      cur_last <= hop_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout     <= rdbp_pkg::TIMEOUT_RESET;
      count       <= '0;
      withdraw_id <= '0;
      have_route  <= 1'b0;
      best_len    <= '0;
      hop_pos     <= '0;
      verdict     <= rdbp_pkg::VERDICT_EQ;
      age         <= '0;
      best_bank   <= 1'b0;
      exp_flag    <= 1'b0;
      rd_idx      <= '0;
      clr_addr    <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      clr_addr <= cmd.clr_sweep ? clr_addr + 1'b1 : '0;
      if (cmd.load_item) begin
        exp_flag <= 1'b0;
        rd_idx   <= '0;
      end
      if (cmd.rd_advance) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmd.wd_update && wd_hit && count != '0) begin
        count <= count - 1'b1;
      end
      if (cmd.note_update && note_new) begin
        count <= count + 1'b1;
        age   <= '0;
        if (cur_func == rdbp_pkg::FUNC_DISCOVER) begin
          withdraw_id <= cur_src;
        end
      end
      if (cmd.hop_update && hop_in) begin
        if (have_route && verdict == rdbp_pkg::VERDICT_EQ && hop_pos < best_len) begin
          if (cur_node < path_rdata) begin
            verdict <= rdbp_pkg::VERDICT_LT;
          end else if (cur_node > path_rdata) begin
            verdict <= rdbp_pkg::VERDICT_GT;
          end
        end
        hop_pos <= hop_pos + 1'b1;
      end
      if (cmd.hop_finish) begin
        if (new_wins) begin
          best_bank <= ~best_bank;
          best_len  <= n_hops;
        end
        have_route <= 1'b1;
        hop_pos    <= '0;
        verdict    <= rdbp_pkg::VERDICT_EQ;
      end
      if (cmd.tick) begin
        age <= age_inc;
        if (expire_now) begin
          count       <= '0;
          withdraw_id <= '0;
          have_route  <= 1'b0;
          best_len    <= '0;
          hop_pos     <= '0;
          verdict     <= rdbp_pkg::VERDICT_EQ;
          exp_flag    <= 1'b1;
        end
      end
    end
  end

  // result register
  assign count_ext = 32'(count);
  assign blen_ext  = 32'(best_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_path) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status || cmd.emit_path) begin
      out_responses   <= count_ext[rdbp_pkg::RESP_W-1:0];
      out_route_found <= have_route;
      out_best_len    <= blen_ext[rdbp_pkg::LEN_W-1:0];
      out_expired     <= cmd.emit_status && exp_flag;
      out_node        <= cmd.emit_path ? path_rdata : '0;
      out_last        <= cmd.emit_status || rd_last;
    end
  end

  assign sts.func       = cur_func;
  assign sts.hop_last   = cur_last;
  assign sts.best_empty = (best_len == '0);
  assign sts.rd_last    = rd_last;
  assign sts.clr_done   = (clr_addr == NODE_AW'(MAX_NODES - 1));
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.exp_flag   = exp_flag;

endmodule

// File: rtl/rdbp_checker.sv
// ----------------------------------------------------------------------------
// rdbp_checker
// Port level checks of the route discovery best path block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdbp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rdbp_pkg::RESP_W-1:0] out_responses,
  input logic                        out_route_found,
  input logic                        out_expired,
  input logic [rdbp_pkg::LEN_W-1:0]  out_best_len,
  input logic [rdbp_pkg::ID_W-1:0]   out_node,
  input logic                        out_last
);

  // an expiry result shows the record already wiped
  `RDBP_ASSERT(a_expired_cleared, clk, rst, out_valid && out_expired |-> out_responses == '0 && !out_route_found && out_best_len == '0, "expiry result shows a live record")

  // only a path readout spans several results
  `RDBP_ASSERT(a_multi_needs_route, clk, rst, out_valid && !out_last |-> out_route_found && !out_expired, "non-final result without a stored route")

  `RDBP_ASSERT(a_node_needs_route, clk, rst, out_valid && out_node != '0 |-> out_route_found, "path hop shown without a stored route")

  `RDBP_ASSERT(a_result_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(out_responses) && $stable(out_last), "stalled result changed")

  // map sweep follows reset, so no transaction is taken right after it
  `RDBP_ASSERT_NR(a_busy_after_reset, clk, $past(rst) |-> !in_ready, "input taken during reset sweep")

endmodule

bind route_discovery_best_path rdbp_checker u_rdbp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (item.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_responses   (result.responses),
  .out_route_found (result.route_found),
  .out_expired     (result.expired),
  .out_best_len    (result.best_len),
  .out_node        (result.out_node),
  .out_last        (result.out_last)
);

// File: verif/tb_route_discovery_best_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_route_discovery_best_path
// Self-checking bench for the route discovery record. A tracker class keeps
// its own copy of the responder map, best path and age, predicts the status
// or path hops of every accepted item, and checks them in order against the
// result channel. Directed cases come first, then random message traffic
// under several timeout settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_route_discovery_best_path;

  localparam int MAX_NODES = 256;
  localparam int MAX_HOPS  = 16;

  typedef logic [rdbp_pkg::FUNC_W-1:0]    func_t;
  typedef logic [rdbp_pkg::ID_W-1:0]      node_id_t;
  typedef logic [rdbp_pkg::LEN_W-1:0]     len_t;
  typedef logic [rdbp_pkg::TIMEOUT_W-1:0] timeout_t;

  localparam func_t FUNC_SPARE_FIRST = rdbp_pkg::FUNC_READ + 3'd1;
  localparam func_t FUNC_SPARE_LAST  = '1;

  typedef struct packed {
    logic [rdbp_pkg::FUNC_W-1:0] func;
    logic [rdbp_pkg::ID_W-1:0]   responder_id;
    logic [rdbp_pkg::LEN_W-1:0]  path_len;
    logic [rdbp_pkg::ID_W-1:0]   hop_node;
    logic                        hop_last;
  } route_item_t;

  typedef struct packed {
    logic [rdbp_pkg::RESP_W-1:0] responses;
    logic                        route_found;
    logic                        expired;
    logic [rdbp_pkg::LEN_W-1:0]  best_len;
    logic [rdbp_pkg::ID_W-1:0]   out_node;
    logic                        out_last;
  } record_status_t;

  class best_path_tracker;
    bit                           responded [MAX_NODES];
    bit [rdbp_pkg::RESP_W-1:0]    resp_count;
    bit [rdbp_pkg::ID_W-1:0]      withdraw_id;
    bit                           have_route;
    bit [rdbp_pkg::ID_W-1:0]      best_hops [MAX_HOPS];
    bit [rdbp_pkg::LEN_W-1:0]     best_length;
    bit [rdbp_pkg::ID_W-1:0]      cand_hops [MAX_HOPS];
    bit [rdbp_pkg::LEN_W-1:0]     hop_pos;
    rdbp_pkg::verdict_t           verdict;
    bit [rdbp_pkg::AGE_W-1:0]     age;
    bit [rdbp_pkg::TIMEOUT_W-1:0] timeout;
    record_status_t               expected_status [$];
    int unsigned                  mismatches;

    function new();
      clear_record();
      age = '0;
      timeout = rdbp_pkg::TIMEOUT_RESET;
      mismatches = 0;
    endfunction

    function void clear_record();
      foreach (responded[i]) responded[i] = 1'b0;
      resp_count = '0;
      withdraw_id = '0;
      have_route = 1'b0;
      best_length = '0;
      hop_pos = '0;
      verdict = rdbp_pkg::VERDICT_EQ;
    endfunction

    function void set_timeout(bit [rdbp_pkg::TIMEOUT_W-1:0] value);
      timeout = value;
    endfunction

    function void note_responder(bit [rdbp_pkg::ID_W-1:0] id, bit from_discover);
      if (responded[id]) return;
      responded[id] = 1'b1;
      resp_count++;
      age = '0;
      if (from_discover) withdraw_id = id;
    endfunction

    function void route_hop(route_item_t it);
      int lim;
      int n;
      lim = (it.path_len < MAX_HOPS) ? int'(it.path_len) : MAX_HOPS;
      note_responder(it.responder_id, 1'b0);
      if (hop_pos < lim) begin
        cand_hops[hop_pos] = it.hop_node;
        // lexicographic order is settled by the first differing hop
        if (have_route && verdict == rdbp_pkg::VERDICT_EQ && hop_pos < best_length) begin
          if (it.hop_node < best_hops[hop_pos]) verdict = rdbp_pkg::VERDICT_LT;
          else if (it.hop_node > best_hops[hop_pos]) verdict = rdbp_pkg::VERDICT_GT;
        end
        hop_pos++;
      end
      if (!it.hop_last) return;
      n = (hop_pos < lim) ? int'(hop_pos) : lim;
      if (!have_route || best_length > n ||
          (best_length == n && verdict == rdbp_pkg::VERDICT_LT)) begin
        for (int i = 0; i < n; i++) best_hops[i] = cand_hops[i];
        best_length = len_t'(n);
      end
      have_route = 1'b1;
      hop_pos = '0;
      verdict = rdbp_pkg::VERDICT_EQ;
    endfunction

    function void push_status(bit expired_now, bit [rdbp_pkg::ID_W-1:0] node, bit last);
      record_status_t s;
      s.responses   = resp_count;
      s.route_found = have_route;
      s.expired     = expired_now;
      s.best_len    = best_length;
      s.out_node    = node;
      s.out_last    = last;
      expected_status.insert(expected_status.size(), s);
    endfunction

    function void accept_item(route_item_t it);
      bit expired_now;
      expired_now = 1'b0;
      case (it.func)
        rdbp_pkg::FUNC_DISCOVER: begin
          // the previous discover responder is withdrawn first
          if (withdraw_id != 0 && responded[withdraw_id]) begin
            responded[withdraw_id] = 1'b0;
            if (resp_count > 0) resp_count--;
          end
          note_responder(it.responder_id, 1'b1);
        end
        rdbp_pkg::FUNC_NACK: note_responder(it.responder_id, 1'b0);
        rdbp_pkg::FUNC_ROUTE: route_hop(it);
        rdbp_pkg::FUNC_TICK: begin
          if (age < rdbp_pkg::AGE_MAX) age++;
          if (age > timeout) begin
            clear_record();
            expired_now = 1'b1;
          end
        end
        rdbp_pkg::FUNC_READ: begin
          if (best_length == 0) push_status(1'b0, '0, 1'b1);
          else for (int i = 0; i < best_length; i++)
            push_status(1'b0, best_hops[i], i + 1 == best_length);
          return;
        end
        default: ;
      endcase
      push_status(expired_now, '0, 1'b1);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void compare_field(string field, logic [rdbp_pkg::RESP_W-1:0] want,
                                logic [rdbp_pkg::RESP_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(record_status_t got);
      record_status_t want;
      if (expected_status.size() == 0) begin
        $error("result transaction with no status expected: responses %0d best_len %0d",
               got.responses, got.best_len);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("responses", want.responses, got.responses);
      compare_field("route_found", want.route_found, got.route_found);
      compare_field("expired", want.expired, got.expired);
      compare_field("best_len", want.best_len, got.best_len);
      compare_field("out_node", want.out_node, got.out_node);
      compare_field("out_last", want.out_last, got.out_last);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_wr_en = 1'b0;
  timeout_t cfg_wr_data = '0;

  rdbp_in_if  item_ch ();
  rdbp_out_if result_ch ();

  route_discovery_best_path uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  best_path_tracker tracker = new();
  bit steady_flow = 1'b0;
  int items_sent  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic node_id_t pick_source();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return node_id_t'($urandom_range(1, 6));
    if (r == 6) return '0;
    if (r == 7) return '1;
    return node_id_t'($urandom_range(0, 255));
  endfunction

  function automatic len_t pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return len_t'(MAX_HOPS);
    if (r == 2) return len_t'($urandom_range(5, MAX_HOPS - 1));
    return len_t'($urandom_range(1, 4));
  endfunction

  // a small node alphabet makes equal-length ties common
  function automatic node_id_t pick_node();
    if ($urandom_range(0, 9) < 7) return node_id_t'($urandom_range(1, 4));
    return node_id_t'($urandom_range(0, 255));
  endfunction

  task automatic send(input func_t func, input node_id_t src, input len_t plen,
                      input node_id_t node, input logic last);
    route_item_t it;
    int gap;
    it = '{func: func, responder_id: src, path_len: plen, hop_node: node, hop_last: last};
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.func         <= it.func;
    item_ch.responder_id <= it.responder_id;
    item_ch.path_len     <= it.path_len;
    item_ch.hop_node     <= it.hop_node;
    item_ch.hop_last     <= it.hop_last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    tracker.accept_item(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  task automatic cfg_write(input timeout_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_timeout(value);
  endtask

  task automatic random_other();
    func_t func;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) func = rdbp_pkg::FUNC_DISCOVER;
    else if (r < 55) func = rdbp_pkg::FUNC_NACK;
    else if (r < 80) func = rdbp_pkg::FUNC_TICK;
    else if (r < 95) func = rdbp_pkg::FUNC_READ;
    else func = func_t'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    send(func, pick_source(), len_t'($urandom_range(0, MAX_HOPS)),
         node_id_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // mostly well formed messages; some end early, some carry extra hops
  task automatic random_route();
    node_id_t src;
    len_t     plen;
    int count;
    int r;
    src = pick_source();
    plen = pick_len();
    count = int'(plen);
    r = $urandom_range(0, 99);
    if (r < 15 && plen > 1) count = $urandom_range(1, plen - 1);
    else if (r < 25) count = int'(plen) + int'($urandom_range(1, 3));
    if (count == 0) count = 1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) random_other();
      send(rdbp_pkg::FUNC_ROUTE, src, plen, pick_node(), k == count - 1);
    end
  endtask

  task automatic run_random(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 9) < 4) random_route();
      else random_other();
    end
  endtask

  // result side: sample at the edge, then choose the next ready
  initial begin
    int stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        tracker.check_result('{responses: result_ch.responses,
                               route_found: result_ch.route_found,
                               expired: result_ch.expired,
                               best_len: result_ch.best_len,
                               out_node: result_ch.out_node,
                               out_last: result_ch.out_last});
      if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    item_ch.valid        <= 1'b0;
    item_ch.func         <= rdbp_pkg::FUNC_DISCOVER;
    item_ch.responder_id <= '0;
    item_ch.path_len     <= '0;
    item_ch.hop_node     <= '0;
    item_ch.hop_last     <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    cfg_write(16'hFFFF);

    // empty record, spare codes, responder bookkeeping
    send(rdbp_pkg::FUNC_READ, 8'd0, 5'd0, 8'd0, 1'b0);
    send(FUNC_SPARE_FIRST, 8'd77, 5'd16, 8'd255, 1'b1);
    send(FUNC_SPARE_FIRST + 3'd1, 8'd0, 5'd0, 8'd0, 1'b0);
    send(FUNC_SPARE_LAST, 8'd255, 5'd31, 8'd128, 1'b1);
    send(rdbp_pkg::FUNC_NACK, 8'd255, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_DISCOVER, 8'd0, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_DISCOVER, 8'd10, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_DISCOVER, 8'd11, 5'd0, 8'd0, 1'b0);
    // repeat discover withdraws itself and counts again
    send(rdbp_pkg::FUNC_DISCOVER, 8'd11, 5'd0, 8'd0, 1'b0);

    // equal length paths, second one smaller at its last hop
    send(rdbp_pkg::FUNC_ROUTE, 8'd20, 5'd3, 8'd255, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd20, 5'd3, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd20, 5'd3, 8'd128, 1'b1);
    send(rdbp_pkg::FUNC_ROUTE, 8'd21, 5'd3, 8'd255, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd21, 5'd3, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd21, 5'd3, 8'd5, 1'b1);
    send(rdbp_pkg::FUNC_READ, 8'd0, 5'd0, 8'd0, 1'b0);
    // message ends before path_len hops arrived
    send(rdbp_pkg::FUNC_ROUTE, 8'd22, 5'd3, 8'd9, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd22, 5'd3, 8'd9, 1'b1);
    // hops past path_len are dropped
    send(rdbp_pkg::FUNC_ROUTE, 8'd23, 5'd1, 8'd7, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd23, 5'd1, 8'd200, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd23, 5'd1, 8'd201, 1'b1);
    send(rdbp_pkg::FUNC_READ, 8'd0, 5'd0, 8'd0, 1'b0);

    // zero timeout: every tick expires, even after a new responder shows up
    wait_drained();
    cfg_write(16'h0000);
    send(rdbp_pkg::FUNC_TICK, 8'd0, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_TICK, 8'd0, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_NACK, 8'd30, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_ROUTE, 8'd31, 5'd0, 8'd44, 1'b1);
    send(rdbp_pkg::FUNC_READ, 8'd0, 5'd0, 8'd0, 1'b0);
    send(rdbp_pkg::FUNC_TICK, 8'd0, 5'd0, 8'd0, 1'b0);
    for (int k = 0; k < MAX_HOPS; k++)
      send(rdbp_pkg::FUNC_ROUTE, 8'd40, len_t'(MAX_HOPS),
           node_id_t'($urandom_range(0, 255)), k == MAX_HOPS - 1);
    send(rdbp_pkg::FUNC_READ, 8'd0, 5'd0, 8'd0, 1'b0);

    wait_drained();
    cfg_write(16'd3);
    run_random(12);
    // hold off until every pending result is back
    wait_drained();
    cfg_write(16'hFFFF);
    steady_flow = 1'b1;
    run_random(12);
    wait_drained();
    steady_flow = 1'b0;
    cfg_write(timeout_t'($urandom_range(1, 6)));
    run_random(12);
    wait_drained();
    cfg_write(16'h0000);
    run_random(10);

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
